[src/b64e_pkg.sv]
// Package for the base64 stream encoder: item structs, the queued group type
// and the alphabet lookup. No dependencies.
package b64e_pkg;

    // ASCII codes used by the alphabet and the fill character
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    // Sextet boundaries between alphabet ranges
    localparam logic [5:0] SEXTET_LOWER = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT = 6'd52;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;

    // Number of characters in one encoded group
    localparam int unsigned GROUP_CHARS = 4;

    // Input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } b64e_in_t;

    // Result item
    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
    } b64e_out_t;

    // One 24-bit group handed from front to back, with its '=' fill count (0..2)
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  pad_cnt;
    } b64e_group_t;

    // Map a sextet to its character of the standard alphabet
    function automatic logic [7:0] b64e_char(input logic [5:0] sextet);
        logic [7:0] ch;
        if (sextet < SEXTET_LOWER) begin
            ch = CHAR_UPPER_A + {2'b00, sextet};
        end else if (sextet < SEXTET_DIGIT) begin
            ch = CHAR_LOWER_A + {2'b00, sextet - SEXTET_LOWER};
        end else if (sextet < SEXTET_PLUS) begin
            ch = CHAR_ZERO + {2'b00, sextet - SEXTET_DIGIT};
        end else if (sextet == SEXTET_PLUS) begin
            ch = CHAR_PLUS;
        end else begin
            ch = CHAR_SLASH;
        end
        return ch;
    endfunction

endpackage

[src/b64e_front.sv]
// Front end of the base64 encoder: accepts bytes, holds up to two pending bytes
// and pushes complete or flushed groups into the queue. Uses b64e_pkg.
module b64e_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  b64e_pkg::b64e_in_t    s_data,
    input  logic                  q_full,
    output logic                  q_push,
    output b64e_pkg::b64e_group_t q_group
);

    logic [15:0] pend_bytes_reg, pend_bytes_next;
    logic [1:0]  pend_cnt_reg, pend_cnt_next;
    logic        accept;
    logic        completes;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Classify the byte: a group completes on the third byte or on end of message
    always_comb begin
        completes       = (pend_cnt_reg >= 2'd2) || s_data.end_of_message;
        q_group.bits    = {pend_bytes_reg, s_data.data_byte};
        q_group.pad_cnt = 2'd0;
        pend_bytes_next = pend_bytes_reg;
        pend_cnt_next   = pend_cnt_reg;
        unique case (pend_cnt_reg)
            2'd0: begin
                q_group.bits    = {s_data.data_byte, 16'h0000};
                q_group.pad_cnt = 2'd2;
            end
            2'd1: begin
                q_group.bits    = {pend_bytes_reg[15:8], s_data.data_byte, 8'h00};
                q_group.pad_cnt = 2'd1;
            end
            default: begin
                // full group, no fill
                q_group.pad_cnt = 2'd0;
            end
        endcase
        if (accept) begin
            if (completes) begin
                pend_bytes_next = 16'h0000;
                pend_cnt_next   = 2'd0;
            end else if (pend_cnt_reg == 2'd0) begin
                pend_bytes_next = {s_data.data_byte, 8'h00};
                pend_cnt_next   = 2'd1;
            end else begin
                pend_bytes_next = {pend_bytes_reg[15:8], s_data.data_byte};
                pend_cnt_next   = 2'd2;
            end
        end
    end

    assign q_push = accept && completes;

    // Hold pending bytes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bytes_reg <= 16'h0000;
            pend_cnt_reg   <= 2'd0;
        end else begin
            pend_bytes_reg <= pend_bytes_next;
            pend_cnt_reg   <= pend_cnt_next;
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_cnt_reg != 2'd3)
        else $error("pending count reached three");
    a_push_guard: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("group pushed into a full queue");
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |=> pend_cnt_reg == 2'd0)
        else $error("pending state not cleared after group");

endmodule

[src/b64e_queue.sv]
// Small group queue between front and back of the base64 encoder.
// Uses b64e_pkg for the entry type.
module b64e_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  b64e_pkg::b64e_group_t push_group,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output b64e_pkg::b64e_group_t head_group
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    b64e_pkg::b64e_group_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full       = (cnt_reg == CNT_FULL);
    assign empty      = (cnt_reg == '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && !empty;
    assign head_group = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap at the last entry
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_group;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_FULL)
        else $error("queue count beyond depth");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

[src/b64e_back.sv]
// Back end of the base64 encoder: takes one group from the queue and sends
// its four characters, one per cycle while m_ready allows, through an output register. Uses b64e_pkg.
module b64e_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_empty,
    input  b64e_pkg::b64e_group_t q_group,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output b64e_pkg::b64e_out_t   m_data
);

    localparam logic [1:0] IDX_LAST = 2'(b64e_pkg::GROUP_CHARS - 1);

    logic                  busy_reg, busy_next;
    b64e_pkg::b64e_group_t grp_reg, grp_next;
    logic [1:0]            idx_reg, idx_next;
    logic                  m_valid_reg, m_valid_next;
    b64e_pkg::b64e_out_t   m_data_reg, m_data_next;
    logic                  out_load;
    logic                  finishing;
    logic [5:0]            sextet;
    logic                  is_pad;

    assign out_load  = busy_reg && (!m_valid_reg || m_ready);
    assign finishing = out_load && (idx_reg == IDX_LAST);
    assign q_pop     = !q_empty && (!busy_reg || finishing);

    // Pick the sextet for the current character, most significant first
    always_comb begin
        unique case (idx_reg)
            2'd0:    sextet = grp_reg.bits[23:18];
            2'd1:    sextet = grp_reg.bits[17:12];
            2'd2:    sextet = grp_reg.bits[11:6];
            default: sextet = grp_reg.bits[5:0];
        endcase
        is_pad = ({1'b0, idx_reg} >= (3'd4 - {1'b0, grp_reg.pad_cnt}));
    end

    // Advance through the group and load the output register
    always_comb begin
        busy_next    = busy_reg;
        grp_next     = grp_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next         = 1'b1;
            m_data_next.out_char = is_pad ? b64e_pkg::CHAR_PAD : b64e_pkg::b64e_char(sextet);
            m_data_next.run_last = (idx_reg == IDX_LAST);
            idx_next             = idx_reg + 1'b1;
            if (finishing) begin
                busy_next = 1'b0;
            end
        end
        if (q_pop) begin
            busy_next = 1'b1;
            grp_next  = q_group;
            idx_next  = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold payload without reset
    always_ff @(posedge aclk) begin
        grp_reg    <= grp_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_idx_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != 2'd0 |-> busy_reg)
        else $error("character index moved while idle");
    a_last_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        finishing |=> m_valid && m_data.run_last)
        else $error("end of run not marked on fourth character");
    a_pad_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> grp_reg.pad_cnt != 2'd3)
        else $error("group with three fill characters");

endmodule

[src/base64_stream_encoder_top.sv]
// Base64 stream encoder, standard alphabet with '=' fill.
// The group of a completing byte passes through the queue, the back end group register and the output register.
// Throughput: one byte per cycle while the group queue has room; one character
// per cycle out while m_ready allows; 4 characters per 3 bytes on full groups,
// up to 4 per byte when every byte ends a message, set by the single output port.
// Reset (aresetn low, synchronous) clears pending bytes, the queue and output valid.
module base64_stream_encoder_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  b64e_pkg::b64e_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output b64e_pkg::b64e_out_t m_data
);

    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_empty;
    b64e_pkg::b64e_group_t push_group;
    b64e_pkg::b64e_group_t head_group;

    // Accept and group bytes
    b64e_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_group (push_group)
    );

    // Decouple front and back
    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_group (push_group),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head_group (head_group)
    );

    // Emit characters
    b64e_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_group (head_group),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[tb/base64_stream_encoder_top_tb.sv]
// Self-checking testbench for base64_stream_encoder_top: drives byte items with
// random gaps, predicts each four-character group and checks every result item.
// Depends on b64e_pkg (item structs and the fill character) and the top level RTL.
module base64_stream_encoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Standard alphabet, symbol 0 in the top byte
    localparam bit [8*64-1:0] B64_SYMBOLS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int unsigned RANDOM_BYTES = 270;
    localparam int unsigned DRAIN_CYCLES = 20;

    // Predict characters from accepted bytes and check result items in order
    class b64_scoreboard;
        logic [15:0]         held_bytes;
        logic [1:0]          held_cnt;
        b64e_pkg::b64e_out_t char_q[$];
        int unsigned         errors;

        function new();
            held_bytes = '0;
            held_cnt   = '0;
            errors     = 0;
        endfunction

        function logic [7:0] symbol(input logic [5:0] idx);
            return B64_SYMBOLS[8*(63 - idx) +: 8];
        endfunction

        // Update the held bytes and queue the group that this byte completes
        function void note_byte(input b64e_pkg::b64e_in_t item);
            logic [23:0]         group;
            int                  n_data;
            b64e_pkg::b64e_out_t want;
            if (held_cnt == 2'd0 && !item.end_of_message) begin
                held_bytes = {item.data_byte, 8'h00};
                held_cnt   = 2'd1;
                return;
            end
            if (held_cnt == 2'd1 && !item.end_of_message) begin
                held_bytes[7:0] = item.data_byte;
                held_cnt        = 2'd2;
                return;
            end
            if (held_cnt == 2'd0) begin
                group  = {item.data_byte, 16'h0000};
                n_data = 1;
            end else if (held_cnt == 2'd1) begin
                group  = {held_bytes[15:8], item.data_byte, 8'h00};
                n_data = 2;
            end else begin
                // full group; a count of three is treated as two
                group  = {held_bytes, item.data_byte};
                n_data = 3;
            end
            for (int k = 0; k < 4; k++) begin
                want.out_char = (k <= n_data) ? symbol(group[23-6*k -: 6])
                                              : b64e_pkg::CHAR_PAD;
                want.run_last = (k == 3);
                char_q = {char_q, want};
            end
            held_bytes = '0;
            held_cnt   = '0;
        endfunction

        function void check_char(input b64e_pkg::b64e_out_t got);
            b64e_pkg::b64e_out_t want;
            if (char_q.size() == 0) begin
                $error("unexpected item: out_char %h run_last %b", got.out_char, got.run_last);
                errors++;
                return;
            end
            want = char_q.pop_front();
            if (got.out_char !== want.out_char) begin
                $error("out_char: expected %h, got %h", want.out_char, got.out_char);
                errors++;
            end
            if (got.run_last !== want.run_last) begin
                $error("run_last: expected %b, got %b", want.run_last, got.run_last);
                errors++;
            end
        endfunction

        function int outstanding();
            return char_q.size();
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    b64e_pkg::b64e_in_t  s_data;
    logic                m_valid;
    logic                m_ready;
    b64e_pkg::b64e_out_t m_data;

    b64_scoreboard sb = new();
    bit            calm_mode = 1'b0;
    int unsigned   sent_bytes = 0;

    base64_stream_encoder_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mostly short gaps, a few long ones, none in a calm stretch
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_mode || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one item after an optional gap and hold it until accepted
    task automatic send_byte(input b64e_pkg::b64e_in_t item);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(item);
        sent_bytes++;
    endtask

    // Send a message; the flag goes on its final byte
    task automatic send_message(input logic [7:0] bytes[$]);
        b64e_pkg::b64e_in_t item;
        for (int i = 0; i < bytes.size(); i++) begin
            item.data_byte      = bytes[i];
            item.end_of_message = (i == bytes.size() - 1);
            send_byte(item);
        end
    endtask

    task automatic send_random_message();
        logic [7:0] bytes[$];
        int         len;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(1, 6);
        else if (r < 95) len = $urandom_range(7, 15);
        else len = $urandom_range(16, 40);
        for (int i = 0; i < len; i++) bytes = {bytes, 8'($urandom_range(0, 255))};
        send_message(bytes);
    endtask

    // Receive side: check accepted items, stall at random
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_char(m_data);
            if (stall_left == 0 && !calm_mode) stall_left = pick_gap();
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Main sequence: reset, directed messages, random messages, drain
    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // one and two byte messages at the byte extremes
        calm_mode = 1'b1;
        send_message('{8'h00});
        send_message('{8'hFF});
        calm_mode = 1'b0;
        send_message('{8'h00, 8'hFF});
        send_message('{8'hFF, 8'h00});
        // flag on the third byte; all '/' then all '+'
        send_message('{8'hFF, 8'hFF, 8'hFF});
        send_message('{8'hFB, 8'hEF, 8'hBE});
        // full group without the flag, then a two byte tail
        send_message('{8'h00, 8'h00, 8'h00, 8'h4D, 8'h61});
        // full group, then a one byte tail; then a full group with a two byte tail
        send_message('{8'h80, 8'h01, 8'h7F, 8'h55});
        send_message('{8'hAA, 8'h55, 8'h01, 8'hFE, 8'h10});

        // random messages, some in calm stretches
        while (sent_bytes < RANDOM_BYTES) begin
            calm_mode = ($urandom_range(0, 99) < 20);
            send_random_message();
        end
        calm_mode = 1'b0;
        s_valid <= 1'b0;

        // drain, then watch for stray items
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("[base64_stream_encoder_top] OK");
        end else begin
            $display("[base64_stream_encoder_top] ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("[base64_stream_encoder_top] ERROR");
        $finish;
    end

endmodule
